[sv/adaptive_scalar_kalman_filter_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive scalar Kalman filter
// Shared concurrent-assertion wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_SCALAR_KALMAN_FILTER_MACROS_SVH
`define ADAPTIVE_SCALAR_KALMAN_FILTER_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASKF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASKF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/askf_pkg.sv]
// ----------------------------------------------------------------------------
// askf_pkg
// Types and constants shared by the adaptive scalar Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none
package askf_pkg;
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_EST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VAR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_Q    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_R    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RAISE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_Q_MAX     = 3'd7;

    localparam logic [31:0] U32MAX = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HIST,
        S_PAIR,
        S_THR,
        S_NOISE,
        S_PRED,
        S_DIV,
        S_CORR,
        S_VAR,
        S_OUT
    } t_state;

    // multiplier operand select
    typedef enum logic [2:0] {
        M_DIFF,
        M_THR,
        M_NOISE,
        M_CORR,
        M_VAR
    } t_mul_sel;

    typedef struct packed {
        logic        start;
        logic [32:0] num;
        logic [32:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [16:0] quo;
    } t_div_rsp;
endpackage
`default_nettype wire

[sv/askf_div.sv]
// ----------------------------------------------------------------------------
// askf_div
// Restoring serial divider: gain = floor(P * 65536 / den), one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module askf_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire askf_pkg::t_div_req i_req,
    output askf_pkg::t_div_rsp     o_rsp
);
    import askf_pkg::*;

    // quotient is at most 65536, needs 17 bits
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [16:0] r_quo;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] r_num_lo;
    logic [33:0] n_trial;
    logic [33:0] n_shift;

    // num << 16 has bits 48:0; top 32 bits (48:17) seed remainder
    always_comb begin
        n_shift = {r_rem[32:0], r_num_lo[16]};
        n_trial = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd17;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem    <= {2'b00, i_req.num[32:1]};
            r_num_lo <= {i_req.num[0], 16'd0};
            r_den    <= i_req.den;
            r_quo    <= '0;
        end else if (r_busy) begin
            r_num_lo <= {r_num_lo[15:0], 1'b0};
            if (!n_trial[33]) begin
                r_rem <= n_trial;
                r_quo <= {r_quo[15:0], 1'b1};
            end else begin
                r_rem <= n_shift;
                r_quo <= {r_quo[15:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule
`default_nettype wire

[sv/askf_core.sv]
// ----------------------------------------------------------------------------
// askf_core
// Sequencer with one shared 33x33 multiplier and two accumulators.
// ----------------------------------------------------------------------------
`default_nettype none
module askf_core #(
    parameter int unsigned WINDOW_LEN = 5
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_kind,
    input  wire logic [31:0]        i_meas,
    input  wire logic [31:0]        i_init_est,
    input  wire logic [31:0]        i_init_var,
    input  wire logic [31:0]        i_base_q,
    input  wire logic [31:0]        i_meas_r,
    input  wire logic [30:0]        i_thresh,
    input  wire logic [15:0]        i_raise,
    input  wire logic [12:0]        i_decay,
    input  wire logic [31:0]        i_q_max,
    output askf_pkg::t_div_req      o_div_req,
    input  wire askf_pkg::t_div_rsp i_div_rsp,
    output logic                    o_done,
    output logic                    o_busy,
    output logic [31:0]             o_est,
    output logic                    o_fast
);
    import askf_pkg::*;

    localparam int unsigned PTR_W = $clog2(WINDOW_LEN);
    localparam int unsigned NPAIR = WINDOW_LEN * (WINDOW_LEN - 1) / 2;
    localparam int unsigned NSQ   = WINDOW_LEN * WINDOW_LEN;
    localparam int unsigned CNT_W = $clog2(NSQ + 1);
    localparam int unsigned ACC_W = 64 + CNT_W;

    t_state r_state, n_state;

    logic [31:0] r_hist [WINDOW_LEN];
    logic [PTR_W-1:0] r_ptr;
    logic [PTR_W-1:0] r_ia, r_ib;
    logic [CNT_W-1:0] r_cnt;
    logic [ACC_W-1:0] r_lhs, r_rhs;
    logic [63:0] r_th2;
    logic signed [31:0] r_est;
    logic [31:0] r_var, r_q, r_p, r_mag;
    logic        r_neg;
    logic [16:0] r_k;
    logic        r_fast;
    logic [65:0] r_prod;
    logic        r_mul_vld;

    t_mul_sel    n_msel;
    logic [32:0] n_ma, n_mb;
    logic [31:0] n_a, n_b, n_d;
    logic signed [32:0] n_res;
    logic [32:0] n_psum;
    logic [47:0] n_shq;
    logic signed [33:0] n_x;
    logic [32:0] n_den;

    always_comb begin
        n_a = r_hist[r_ia];
        n_b = r_hist[r_ib];
        n_d = (n_a > n_b) ? n_a - n_b : n_b - n_a;
        n_res = $signed({i_meas[31], i_meas}) - $signed({r_est[31], r_est});
        n_psum = {1'b0, r_var} + {1'b0, r_q};
        n_shq = r_prod[59:12];
        n_den = {1'b0, r_p} + {1'b0, i_meas_r};
        n_x = r_neg ? ({{2{r_est[31]}}, r_est} - {1'b0, r_prod[48:16]} -
                       34'(r_prod[15]))
                    : ({{2{r_est[31]}}, r_est} + {1'b0, r_prod[48:16]} +
                       34'(r_prod[15]));
    end

    // shared multiplier operand mux
    always_comb begin
        n_msel = M_DIFF;
        case (r_state)
            S_THR:   n_msel = M_THR;
            S_NOISE: n_msel = M_NOISE;
            S_CORR:  n_msel = M_CORR;
            S_VAR:   n_msel = M_VAR;
            default: n_msel = M_DIFF;
        endcase
        case (n_msel)
            M_DIFF:  begin n_ma = {1'b0, n_d};        n_mb = {1'b0, n_d}; end
            M_THR:   begin n_ma = {2'b0, i_thresh};   n_mb = {2'b0, i_thresh}; end
            M_NOISE: begin
                n_ma = {1'b0, r_q};
                n_mb = r_fast ? {17'd0, i_raise} : {20'd0, i_decay};
            end
            M_CORR:  begin n_ma = {16'd0, r_k};       n_mb = {1'b0, r_mag}; end
            M_VAR:   begin n_ma = 33'h1_0000 - {16'd0, r_k}; n_mb = {1'b0, r_p}; end
            default: begin n_ma = '0;                 n_mb = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_ma * n_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_start) n_state = i_kind ? S_OUT : S_HIST;
            S_HIST:  n_state = S_PAIR;
            S_PAIR:  if (r_cnt == CNT_W'(NPAIR)) n_state = S_THR;
            S_THR:   if (r_cnt == CNT_W'(NSQ + 1)) n_state = S_NOISE;
            S_NOISE: if (r_mul_vld) n_state = S_PRED;
            S_PRED:  n_state = S_DIV;
            S_DIV:   if (i_div_rsp.done) n_state = S_CORR;
            S_CORR:  if (r_mul_vld) n_state = S_VAR;
            S_VAR:   if (r_mul_vld) n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est <= '0; r_var <= '0; r_q <= '0; r_ptr <= '0;
            r_fast <= 1'b0; r_mul_vld <= 1'b0;
            for (int i = 0; i < WINDOW_LEN; i++) r_hist[i] <= '0;
        end else begin
            r_mul_vld <= 1'b0;
            case (r_state)
                S_IDLE: if (i_start) begin
                    if (i_kind) begin
                        r_est <= i_init_est; r_var <= i_init_var; r_q <= i_base_q;
                        r_ptr <= '0; r_fast <= 1'b0;
                        for (int i = 0; i < WINDOW_LEN; i++) r_hist[i] <= '0;
                    end else begin
                        r_neg <= n_res[32];
                        r_mag <= n_res[32] ? 32'(-n_res) : n_res[31:0];
                    end
                end
                S_HIST: begin
                    r_hist[r_ptr] <= r_mag;
                    r_ptr <= (r_ptr == PTR_W'(WINDOW_LEN - 1)) ? '0 : r_ptr + 1'b1;
                    r_ia <= '0; r_ib <= PTR_W'(1); r_cnt <= '0;
                    r_lhs <= '0; r_rhs <= '0;
                end
                S_PAIR: begin
                    // product of previous pair is registered, so it lands in the next cycle
                    if (r_cnt != '0) r_lhs <= r_lhs + ACC_W'(r_prod[63:0]);
                    r_cnt <= r_cnt + 1'b1;
                    if (r_ib == PTR_W'(WINDOW_LEN - 1)) begin
                        r_ia <= r_ia + 1'b1; r_ib <= r_ia + PTR_W'(2);
                    end else r_ib <= r_ib + 1'b1;
                    if (r_cnt == CNT_W'(NPAIR)) r_cnt <= '0;
                end
                S_THR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(1)) r_th2 <= r_prod[63:0];
                    if (r_cnt >= CNT_W'(2)) r_rhs <= r_rhs + ACC_W'(r_th2);
                    if (r_cnt == CNT_W'(NSQ + 1)) begin
                        r_fast <= r_lhs > (r_rhs + ACC_W'(r_th2));
                        r_mul_vld <= 1'b0;
                    end
                end
                S_NOISE: begin
                    r_mul_vld <= 1'b1;
                    if (r_mul_vld) begin
                        if (r_fast)
                            r_q <= (n_shq > {16'd0, i_q_max}) ? i_q_max : n_shq[31:0];
                        else if (n_shq < {16'd0, i_base_q}) r_q <= i_base_q;
                        else if (n_shq[47:32] != '0) r_q <= U32MAX;
                        else r_q <= n_shq[31:0];
                        r_mul_vld <= 1'b0;
                    end
                end
                S_PRED: r_p <= n_psum[32] ? U32MAX : n_psum[31:0];
                // zero denominator gives zero gain
                S_DIV: if (i_div_rsp.done) r_k <= (n_den == '0) ? '0 : i_div_rsp.quo;
                S_CORR: begin
                    r_mul_vld <= !r_mul_vld;
                    if (r_mul_vld) begin
                        if (n_x > 34'sh7FFF_FFFF) r_est <= 32'h7FFF_FFFF;
                        else if (n_x < -34'sh8000_0000) r_est <= 32'h8000_0000;
                        else r_est <= n_x[31:0];
                    end
                end
                S_VAR: begin
                    r_mul_vld <= !r_mul_vld;
                    if (r_mul_vld) r_var <= r_prod[47:16];
                end
                default: ;
            endcase
        end
    end

    assign o_div_req.start = (r_state == S_PRED);
    assign o_div_req.num   = {1'b0, n_psum[32] ? U32MAX : n_psum[31:0]};
    assign o_div_req.den   = {1'b0, n_psum[32] ? U32MAX : n_psum[31:0]} + {1'b0, i_meas_r};
    assign o_done = (r_state == S_OUT);
    assign o_busy = (r_state != S_IDLE);
    assign o_est  = r_est;
    assign o_fast = r_fast;
endmodule
`default_nettype wire

[sv/adaptive_scalar_kalman_filter.sv]
// ----------------------------------------------------------------------------
// adaptive_scalar_kalman_filter
// One-state Kalman filter with adaptive process noise, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis: tuser = kind (0 sample, 1 reinitialize), tdata = measurement
//  (Q19.12 signed). m_axis: tdata = estimate, tuser = fast_tracking.
//  Config: i_cfg_we / i_cfg_idx / i_cfg_data, write only while idle.
//  One transaction at a time: a sample's result waits on the shared
//  multiplier walking the window pairs and the threshold sum and on the
//  serial gain divide; a reinitialize's result goes from the S_OUT state
//  straight into the output register.
//  With a ready receiver the next transaction is accepted once the
//  previous result is taken.
//  s_axis_tready is low from acceptance until the result is taken.
//  A stalled receiver holds the result in the output register.
//  Reset clears filter state and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "adaptive_scalar_kalman_filter_macros.svh"
module adaptive_scalar_kalman_filter #(
    parameter int unsigned WINDOW_LEN = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] measurement
    input  wire logic        s_axis_tuser,   // [0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] estimate
    output logic             m_axis_tuser,   // [0] fast_tracking
    input  wire logic        i_cfg_we,
    input  wire logic [askf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    import askf_pkg::*;

    logic [31:0] r_init_est, r_init_var, r_base_q, r_meas_r, r_q_max;
    logic [30:0] r_thresh;
    logic [15:0] r_raise;
    logic [12:0] r_decay;
    logic        r_busy, r_ovld;
    logic        w_done, w_cbusy, w_fast;
    logic [31:0] w_est;
    t_div_req    w_req;
    t_div_rsp    w_rsp;
    logic        w_in_acc;

    assign s_axis_tready = !r_busy;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_est <= 32'd0; r_init_var <= 32'd65536; r_base_q <= 32'd655;
            r_meas_r <= 32'd65536; r_thresh <= 31'd4096; r_raise <= 16'd6144;
            r_decay <= 13'd3891; r_q_max <= 32'd655360;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_INIT_EST: r_init_est <= i_cfg_data;
                REG_INIT_VAR: r_init_var <= i_cfg_data;
                REG_BASE_Q:   r_base_q   <= i_cfg_data;
                REG_MEAS_R:   r_meas_r   <= i_cfg_data;
                REG_THRESH:   r_thresh   <= i_cfg_data[30:0];
                REG_RAISE:    r_raise    <= i_cfg_data[15:0];
                REG_DECAY:    r_decay    <= i_cfg_data[12:0];
                REG_Q_MAX:    r_q_max    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_ovld <= 1'b0;
        end else begin
            if (w_in_acc) r_busy <= 1'b1;
            if (w_done) r_ovld <= 1'b1;
            if (r_ovld && m_axis_tready) begin
                r_ovld <= 1'b0; r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            m_axis_tdata <= w_est;
            m_axis_tuser <= w_fast;
        end
    end
    assign m_axis_tvalid = r_ovld;

    askf_div u_div (.i_clk, .i_rst_n, .i_req(w_req), .o_rsp(w_rsp));

    askf_core #(.WINDOW_LEN(WINDOW_LEN)) u_core (
        .i_clk, .i_rst_n,
        .i_start(w_in_acc), .i_kind(s_axis_tuser), .i_meas(s_axis_tdata),
        .i_init_est(r_init_est), .i_init_var(r_init_var), .i_base_q(r_base_q),
        .i_meas_r(r_meas_r), .i_thresh(r_thresh), .i_raise(r_raise),
        .i_decay(r_decay), .i_q_max(r_q_max),
        .o_div_req(w_req), .i_div_rsp(w_rsp),
        .o_done(w_done), .o_busy(w_cbusy), .o_est(w_est), .o_fast(w_fast)
    );

    `ASKF_ASSERT_IMPL(a_no_acc_busy, i_clk, i_rst_n, w_cbusy, !s_axis_tready)
    `ASKF_ASSERT_IMPL(a_done_free, i_clk, i_rst_n, w_done, !r_ovld)
    `ASKF_ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, w_done, m_axis_tvalid)
endmodule
`default_nettype wire

[verif/askf_checker.sv]
// ----------------------------------------------------------------------------
// askf_checker
// Watches the input, output and register-write ports of the adaptive scalar
// Kalman filter, predicts each result with a bit-exact filter model and
// compares estimate and fast_tracking in order.
// ----------------------------------------------------------------------------
module askf_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_in_data,
    input  logic        i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,
    input  logic        i_out_user,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    import askf_pkg::*;

    localparam int WIN = 5;

    typedef struct packed {
        logic [31:0] est;
        logic        fast;
    } t_estimate;

    logic [31:0] r_init_est, r_init_var, r_base_q, r_meas_r, r_thr, r_raise, r_decay, r_q_max;
    logic signed [31:0] m_est;
    logic [31:0] m_var, m_q;
    logic [31:0] m_hist [WIN];
    int          m_ptr;
    t_estimate   est_fifo [$];

    assign o_pending = est_fifo.size();

    function automatic t_estimate filter_step(input logic kind, input logic [31:0] meas);
        t_estimate r;
        logic signed [33:0] res, x;
        logic [33:0] mag;
        logic [127:0] pair_sum, thr_sum;
        logic [63:0] d, prod, p, den, k, corr;
        logic fast;
        if (kind) begin
            m_est = r_init_est;
            m_var = r_init_var;
            m_q = r_base_q;
            for (int i = 0; i < WIN; i++) m_hist[i] = '0;
            m_ptr = 0;
            r.est = m_est;
            r.fast = 1'b0;
            return r;
        end
        res = $signed({{2{meas[31]}}, meas}) - $signed({{2{m_est[31]}}, m_est});
        mag = res < 0 ? -res : res;
        m_hist[m_ptr] = mag[31:0];
        m_ptr = (m_ptr + 1) % WIN;
        pair_sum = '0;
        for (int i = 0; i < WIN; i++)
            for (int j = i + 1; j < WIN; j++) begin
                d = 64'(m_hist[i] > m_hist[j] ? m_hist[i] - m_hist[j]
                                               : m_hist[j] - m_hist[i]);
                pair_sum += 128'(d * d);
            end
        thr_sum = 128'(64'(r_thr) * 64'(r_thr)) * 128'(25);
        fast = pair_sum > thr_sum;
        if (fast) begin
            prod = (64'(m_q) * 64'(r_raise)) >> 12;
            if (prod > 64'(r_q_max)) prod = 64'(r_q_max);
        end else begin
            prod = (64'(m_q) * 64'(r_decay)) >> 12;
            if (prod < 64'(r_base_q)) prod = 64'(r_base_q);
            if (prod > 64'(U32MAX)) prod = 64'(U32MAX);
        end
        m_q = prod[31:0];
        p = 64'(m_var) + 64'(m_q);
        if (p > 64'(U32MAX)) p = 64'(U32MAX);
        den = p + 64'(r_meas_r);
        k = den != 64'd0 ? (p << 16) / den : 64'd0;
        corr = (k * 64'(mag) + 64'd32768) >> 16;
        x = res < 0 ? 34'(m_est) - $signed(34'(corr)) : 34'(m_est) + $signed(34'(corr));
        if (x > 34'sh7FFF_FFFF) x = 34'sh7FFF_FFFF;
        if (x < -34'sh8000_0000) x = -34'sh8000_0000;
        m_est = x[31:0];
        m_var = 32'(((64'd65536 - k) * p) >> 16);
        r.est = m_est;
        r.fast = fast;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_estimate exp_r;
        if (!i_rst_n) begin
            r_init_est <= 0; r_init_var <= 65536; r_base_q <= 655; r_meas_r <= 65536;
            r_thr <= 4096; r_raise <= 6144; r_decay <= 3891; r_q_max <= 655360;
            m_est = 0; m_var = 0; m_q = 0; m_ptr = 0;
            for (int i = 0; i < WIN; i++) m_hist[i] = '0;
            est_fifo.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_INIT_EST: r_init_est <= i_cfg_data;
                    REG_INIT_VAR: r_init_var <= i_cfg_data;
                    REG_BASE_Q:   r_base_q   <= i_cfg_data;
                    REG_MEAS_R:   r_meas_r   <= i_cfg_data;
                    REG_THRESH:   r_thr      <= {1'b0, i_cfg_data[30:0]};
                    REG_RAISE:    r_raise    <= {16'd0, i_cfg_data[15:0]};
                    REG_DECAY:    r_decay    <= {19'd0, i_cfg_data[12:0]};
                    REG_Q_MAX:    r_q_max    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                est_fifo.push_back(filter_step(i_in_user, i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (est_fifo.size() == 0) begin
                    $display("%0t: unexpected transaction est=%h fast=%b",
                             $time, i_out_data, i_out_user);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = est_fifo.pop_front();
                    if (exp_r.est !== i_out_data || exp_r.fast !== i_out_user) begin
                        $display("%0t: mismatch expected est=%h fast=%b actual est=%h fast=%b",
                                 $time, exp_r.est, exp_r.fast, i_out_data, i_out_user);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the adaptive scalar Kalman filter: directed extremes, then
// phases of random samples and reinitializes under several register settings
// with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;
    import askf_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] measurement
    logic        s_axis_tuser = 1'b0; // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] estimate
    logic        m_axis_tuser;        // [0] fast_tracking
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    int          errors, pending;
    int          send_idle = 0, recv_idle = 0;
    logic [31:0] last_meas = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    adaptive_scalar_kalman_filter i_dut (.*);

    askf_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_user(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle);

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // valid stays high after a transaction until the next idle cycle or drain
    task automatic send_item(input logic kind, input logic [31:0] meas);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= meas;
        do @(posedge i_clk); while (!s_axis_tready);
        if (!kind) last_meas = meas;
    endtask

    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_meas;
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return last_meas + 32'($signed($urandom_range(8192)) - 4096);
            default: return last_meas + 32'($signed($urandom_range(262144)) - 131072);
        endcase
    endfunction

    task automatic random_settings;
        write_reg(REG_INIT_EST, $urandom_range(1) ? $urandom : $urandom_range(65536));
        write_reg(REG_INIT_VAR, $urandom_range(1) ? $urandom : $urandom_range(1 << 20));
        write_reg(REG_BASE_Q, $urandom_range(3) == 0 ? $urandom : $urandom_range(4096));
        write_reg(REG_MEAS_R, $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 18));
        write_reg(REG_THRESH, $urandom_range(3) == 0 ? $urandom : $urandom_range(65536));
        write_reg(REG_RAISE, $urandom_range(3) == 0 ? $urandom : $urandom_range(4096, 12288));
        write_reg(REG_DECAY, $urandom_range(8191));
        write_reg(REG_Q_MAX, $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 22));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: default settings, then extremes
        send_item(1'b0, 32'h0000_1000);
        send_item(1'b0, 32'h7FFF_FFFF);
        send_item(1'b0, 32'h8000_0000);
        send_item(1'b0, 32'h7FFF_FFFF);
        send_item(1'b1, 32'hFFFF_FFFF);
        send_item(1'b0, 32'h0000_0000);
        drain_results();
        // zero gain denominator, zero cap and floor, decay above one
        write_reg(REG_INIT_EST, 32'h8000_0000);
        write_reg(REG_INIT_VAR, 32'd0);
        write_reg(REG_BASE_Q, 32'd0);
        write_reg(REG_MEAS_R, 32'd0);
        write_reg(REG_THRESH, 32'd0);
        write_reg(REG_RAISE, 32'hFFFF);
        write_reg(REG_DECAY, 32'h1FFF);
        write_reg(REG_Q_MAX, 32'd0);
        send_item(1'b1, 32'd0);
        send_item(1'b0, 32'h7FFF_FFFF);
        send_item(1'b0, 32'h7FFF_FFFF);
        drain_results();
        write_reg(REG_INIT_VAR, 32'hFFFF_FFFF);
        write_reg(REG_BASE_Q, 32'hFFFF_FFFF);
        write_reg(REG_MEAS_R, 32'hFFFF_FFFF);
        write_reg(REG_THRESH, 32'h7FFF_FFFF);
        write_reg(REG_Q_MAX, 32'hFFFF_FFFF);
        send_item(1'b1, 32'd0);
        for (int i = 0; i < 6; i++) send_item(1'b0, $urandom);
        drain_results();
        write_reg(REG_BASE_Q, 32'd100);
        write_reg(REG_THRESH, 32'd1);
        write_reg(REG_Q_MAX, 32'd10);
        write_reg(REG_MEAS_R, 32'd65536);
        send_item(1'b1, 32'd0);
        send_item(1'b0, 32'h0010_0000);
        send_item(1'b0, 32'hFFF0_0000);
        drain_results();
        // random phases
        for (int ph = 0; ph < 12; ph++) begin
            send_idle = ph < 4 ? 20 : (ph < 8 ? 78 : 0);
            recv_idle = ph < 4 ? 78 : (ph < 8 ? 20 : 0);
            random_settings();
            send_item(1'b1, $urandom);
            for (int n = 0; n < 120; n++) begin
                if ($urandom_range(39) == 0) send_item(1'b1, $urandom);
                else send_item(1'b0, random_meas());
            end
            drain_results();
        end
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("adaptive_scalar_kalman_filter verification clean");
        else
            $display("adaptive_scalar_kalman_filter verification failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("adaptive_scalar_kalman_filter verification failed");
        $finish;
    end
endmodule
